// ----- rtl/psb_pkg.sv -----
// Shared types, constants and helper functions of the post column sprite blitter.
package psb_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int PALETTE_SIZE = 256;

  localparam int DIM_W       = 11;
  localparam int COORD_W     = 12;
  localparam int ADDR_W      = 20;
  localparam int COLOR_W     = 32;
  localparam int BYTE_W      = 8;
  localparam int COLUMN_W    = 10;
  localparam int PAL_ADDR_W  = $clog2(PALETTE_SIZE);
  localparam int ALPHA_SHIFT = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [BYTE_W-1:0] END_MARK = 8'hff;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_COLUMN = 2'd1,
    CMD_BYTE   = 2'd2,
    CMD_NONE   = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    REG_TARGET_X      = 3'd0,
    REG_TARGET_Y      = 3'd1,
    REG_BUFFER_WIDTH  = 3'd2,
    REG_BUFFER_HEIGHT = 3'd3,
    REG_ALPHA_VALUE   = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_TOP,
    PH_LEN,
    PH_PAD,
    PH_PIX,
    PH_TAIL,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [DIM_W-1:0]  target_x;
    logic [DIM_W-1:0]  target_y;
    logic [DIM_W-1:0]  buffer_width;
    logic [DIM_W-1:0]  buffer_height;
    logic [BYTE_W-1:0] alpha_value;
  } cfg_t;

  // One queue entry: either a palette load or a visible pixel job.
  typedef struct packed {
    logic                  is_load;
    logic [PAL_ADDR_W-1:0] index;
    logic [COLOR_W-1:0]    color;
    logic [DIM_W-1:0]      row;
    logic [DIM_W-1:0]      x;
  } job_t;

  function automatic logic [DIM_W-1:0] eff_width(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = (32'(v) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : v;
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] eff_height(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = (32'(v) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : v;
    return r;
  endfunction

endpackage

// ----- rtl/psb_regs.sv -----
// Configuration register file behind the APB-style port.
module psb_regs
  import psb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr_en;
  reg_index_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_index_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_x      <= '0;
      cfg.target_y      <= '0;
      cfg.buffer_width  <= DIM_W'(512);
      cfg.buffer_height <= DIM_W'(200);
      cfg.alpha_value   <= 8'hff;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_TARGET_X:      cfg.target_x      <= pwdata[DIM_W-1:0];
        REG_TARGET_Y:      cfg.target_y      <= pwdata[DIM_W-1:0];
        REG_BUFFER_WIDTH:  cfg.buffer_width  <= pwdata[DIM_W-1:0];
        REG_BUFFER_HEIGHT: cfg.buffer_height <= pwdata[DIM_W-1:0];
        REG_ALPHA_VALUE:   cfg.alpha_value   <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TARGET_X:      prdata = PDATA_W'(cfg.target_x);
      REG_TARGET_Y:      prdata = PDATA_W'(cfg.target_y);
      REG_BUFFER_WIDTH:  prdata = PDATA_W'(cfg.buffer_width);
      REG_BUFFER_HEIGHT: prdata = PDATA_W'(cfg.buffer_height);
      REG_ALPHA_VALUE:   prdata = PDATA_W'(cfg.alpha_value);
      default:           prdata = '0;
    endcase
  end

endmodule

// ----- rtl/psb_front.sv -----
// Front end: accepts beats, parses the post stream and emits load and pixel jobs.
module psb_front
  import psb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [1:0]          command,
  input  logic [BYTE_W-1:0]   palette_index,
  input  logic [COLOR_W-1:0]  palette_color,
  input  logic [COLUMN_W-1:0] column_index,
  input  logic [BYTE_W-1:0]   patch_byte,
  input  logic                q_full,
  output logic                push,
  output job_t                push_job
);

  phase_t              phase, phase_next;
  logic [BYTE_W-1:0]   post_top;
  logic [BYTE_W-1:0]   post_remaining;
  logic [BYTE_W-1:0]   post_row;
  logic [COLUMN_W-1:0] current_column;
  logic                column_visible;

  logic                accept;
  command_t            cmd;
  logic [DIM_W-1:0]    effw, effh;
  logic [COORD_W-1:0]  colx_cur, colx_new, row_sum;
  logic                x_in_cur, x_in_new, pixel_vis;

  assign item_stall = q_full;
  assign accept     = item_valid && !item_stall;
  assign cmd        = command_t'(command);
  assign effw       = eff_width(cfg.buffer_width);
  assign effh       = eff_height(cfg.buffer_height);

  // Signed column position and row, sign extended to one extra bit.
  assign colx_cur = {cfg.target_x[DIM_W-1], cfg.target_x} + COORD_W'(current_column);
  assign colx_new = {cfg.target_x[DIM_W-1], cfg.target_x} + COORD_W'(column_index);
  assign row_sum  = {cfg.target_y[DIM_W-1], cfg.target_y} + COORD_W'(post_top)
                    + COORD_W'(post_row);

  assign x_in_cur  = !colx_cur[COORD_W-1] && (colx_cur[DIM_W-1:0] < effw);
  assign x_in_new  = !colx_new[COORD_W-1] && (colx_new[DIM_W-1:0] < effw);
  assign pixel_vis = column_visible && x_in_cur && !row_sum[COORD_W-1]
                     && (row_sum[DIM_W-1:0] < effh);

  // Next parse phase.
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (cmd)
        CMD_COLUMN: phase_next = PH_TOP;
        CMD_BYTE: begin
          unique case (phase)
            PH_TOP:  phase_next = (patch_byte == END_MARK) ? PH_DONE : PH_LEN;
            PH_LEN:  phase_next = PH_PAD;
            PH_PAD:  phase_next = (post_remaining == '0) ? PH_TAIL : PH_PIX;
            PH_PIX:  phase_next = (post_remaining == BYTE_W'(1)) ? PH_TAIL : PH_PIX;
            PH_TAIL: phase_next = PH_TOP;
            PH_DONE: phase_next = PH_DONE;
            default: phase_next = PH_TOP;
          endcase
        end
        default: phase_next = phase;
      endcase
    end
  end

  // Job output toward the queue.
  always_comb begin
    push             = 1'b0;
    push_job.is_load = (cmd == CMD_LOAD);
    push_job.index   = (cmd == CMD_LOAD) ? palette_index : patch_byte;
    push_job.color   = palette_color;
    push_job.row     = row_sum[DIM_W-1:0];
    push_job.x       = colx_cur[DIM_W-1:0];
    if (accept) begin
      unique case (cmd)
        CMD_LOAD: push = 1'b1;
        CMD_BYTE: push = (phase == PH_PIX) && pixel_vis;
        default:  push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TOP;
      post_top       <= '0;
      post_remaining <= '0;
      post_row       <= '0;
      current_column <= '0;
      column_visible <= 1'b0;
    end else begin
      phase <= phase_next;
      if (accept && cmd == CMD_COLUMN) begin
        current_column <= column_index;
        post_top       <= '0;
        post_remaining <= '0;
        post_row       <= '0;
        column_visible <= x_in_new;
      end else if (accept && cmd == CMD_BYTE) begin
        if (phase == PH_TOP && patch_byte != END_MARK) begin
          post_top <= patch_byte;
          post_row <= '0;
        end
        if (phase == PH_LEN) begin
          post_remaining <= patch_byte;
        end
        if (phase == PH_PIX) begin
          post_row       <= post_row + BYTE_W'(1);
          post_remaining <= post_remaining - BYTE_W'(1);
        end
      end
    end
  end

endmodule

// ----- rtl/psb_queue.sv -----
// Short job queue between the parser and the pixel back end.
module psb_queue
  import psb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic not_empty,
  output logic full
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/psb_back.sv -----
// Back end: palette memory, address multiply and the output register.
module psb_back
  import psb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              q_not_empty,
  input  job_t              head,
  output logic              pop,
  output logic              pixel_valid,
  input  logic              pixel_stall,
  output logic [ADDR_W-1:0] pixel_address,
  output logic [COLOR_W-1:0] pixel_color
);

  logic [COLOR_W-1:0]   palette [PALETTE_SIZE];
  logic [COLOR_W-1:0]   rdata;
  logic                 s1_valid;
  logic [ADDR_W-1:0]    s1_prod;
  logic [DIM_W-1:0]     s1_x;
  logic [2*DIM_W-1:0]   prod;
  logic                 out_ready, s1_ready, load_pop, pix_pop;

  assign out_ready = !pixel_valid || !pixel_stall;
  assign s1_ready  = !s1_valid || out_ready;
  assign pop       = q_not_empty && (head.is_load || s1_ready);
  assign load_pop  = pop && head.is_load;
  assign pix_pop   = pop && !head.is_load;
  assign prod      = head.row * eff_width(cfg.buffer_width);

  // Loads and reads leave the queue in order, so a read sees every earlier load.
  always_ff @(posedge clk) begin
    if (load_pop) begin
      palette[head.index] <= head.color;
    end
    if (pix_pop) begin
      rdata <= palette[head.index];
    end
  end

  always_ff @(posedge clk) begin
    if (pix_pop) begin
      s1_prod <= prod[ADDR_W-1:0];
      s1_x    <= head.x;
    end
    if (out_ready && s1_valid) begin
      pixel_address <= s1_prod + ADDR_W'(s1_x);
      pixel_color   <= rdata | (COLOR_W'(cfg.alpha_value) << ALPHA_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid    <= pix_pop;
      if (out_ready) pixel_valid <= s1_valid;
    end
  end

endmodule

// ----- rtl/post_column_sprite_blitter_core.sv -----
// Post column sprite blitter: parses sprite column posts into 32-bit pixel buffer writes.
// The block takes one beat per cycle on the item channel and gives at most one pixel beat
// for it. A beat with command 0 loads one palette entry, command 1 starts a column (its
// horizontal visibility is latched then and checked again for every pixel), and command 2
// feeds the next byte of the column in post format: top delta, length, pad, pixel indices,
// trailing pad, with a top delta of 0xff ending the column. Command 3 is ignored. Each
// visible pixel index is looked up in the 256-entry palette, the alpha register is ORed
// into bits 31..24, and the beat goes out at address row * width + x. Pixels outside the
// buffer, whose size is limited to 1024 by 1024, produce no beat. The front parser handles
// one beat every cycle; palette loads and visible pixels go through a four-entry queue to
// the back end, where the palette memory read and the row * width multiply take one stage
// and the output register a second, so a pixel beat passes through the queue, the first
// stage and the output register in turn. The item channel stalls only while that queue is
// full, which happens only after the pixel side has stalled. Configuration must be written
// through the APB-style port only while no pixel is pending; the block does not enforce it.
module post_column_sprite_blitter_core
  import psb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // APB-style configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  // Item channel.
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [1:0]          command,
  input  logic [BYTE_W-1:0]   palette_index,
  input  logic [COLOR_W-1:0]  palette_color,
  input  logic [COLUMN_W-1:0] column_index,
  input  logic [BYTE_W-1:0]   patch_byte,
  // Pixel channel.
  output logic                pixel_valid,
  input  logic                pixel_stall,
  output logic [ADDR_W-1:0]   pixel_address,
  output logic [COLOR_W-1:0]  pixel_color
);

  cfg_t cfg;
  job_t push_job, head;
  logic push, pop, q_full, q_not_empty;

  // The register file holds the buffer placement, size and alpha for both halves.
  psb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The parser decides visibility, so only real work enters the queue.
  psb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .command        (command),
    .palette_index  (palette_index),
    .palette_color  (palette_color),
    .column_index   (column_index),
    .patch_byte     (patch_byte),
    .q_full         (q_full),
    .push           (push),
    .push_job       (push_job)
  );

  psb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Palette loads travel through the queue too, keeping them ordered with the reads.
  psb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_not_empty   (q_not_empty),
    .head          (head),
    .pop           (pop),
    .pixel_valid   (pixel_valid),
    .pixel_stall   (pixel_stall),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color)
  );

endmodule

// ----- rtl/psb_checker.sv -----
// Port-level checker for the post column sprite blitter, bound to the top level.
module psb_checker
  import psb_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [PADDR_W-1:0]  paddr,
  input logic [PDATA_W-1:0]  pwdata,
  input logic [PDATA_W-1:0]  prdata,
  input logic                pready,
  input logic                item_valid,
  input logic                item_stall,
  input logic [1:0]          command,
  input logic [BYTE_W-1:0]   palette_index,
  input logic [COLOR_W-1:0]  palette_color,
  input logic [COLUMN_W-1:0] column_index,
  input logic [BYTE_W-1:0]   patch_byte,
  input logic                pixel_valid,
  input logic                pixel_stall,
  input logic [ADDR_W-1:0]   pixel_address,
  input logic [COLOR_W-1:0]  pixel_color
);

  // A stalled pixel beat holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_address)
      && $stable(pixel_color))
    else $error("pixel beat changed while stalled");

  // Nothing leaves the block in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !pixel_valid)
    else $error("pixel beat right after reset");

  // An alpha write reads back on the following read of the same register.
  a_alpha_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_ALPHA_VALUE)
      ##1 (psel && !pwrite && paddr == $past(paddr))
      |-> prdata == PDATA_W'($past(pwdata[BYTE_W-1:0])))
    else $error("alpha register read back wrong value");

  // Addresses past the register list read as zero.
  a_unmapped_zero: assert property (@(posedge clk) disable iff (rst)
    psel && !pwrite && paddr[PADDR_W-1:2] > REG_ALPHA_VALUE |-> prdata == '0)
    else $error("unmapped register read nonzero");

endmodule

bind post_column_sprite_blitter_core psb_checker u_checker (.*);
